>>> rtl/tvsc_pkg.sv
package tvsc_pkg;

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [16:0] HALF_LSB   = 17'h08000;
    localparam int          APB_ADDR_W = 5;
    localparam int          APB_DATA_W = 32;
    localparam int          QUEUE_DEPTH = 2;
    localparam int          QPTR_W      = 1;

    // register indexes, byte address is 4 times the index
    localparam logic [2:0] REG_LIMIT0  = 3'd0;
    localparam logic [2:0] REG_LIMIT1  = 3'd1;
    localparam logic [2:0] REG_FLIP0   = 3'd2;
    localparam logic [2:0] REG_FLIP1   = 3'd3;
    localparam logic [2:0] REG_HOLD    = 3'd4;
    localparam logic [2:0] REG_BACKOFF = 3'd5;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        JOB_TICK,
        JOB_OPEN,
        JOB_CLOSE,
        JOB_QUERY,
        JOB_BAD
    } t_job_kind;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  valve;
        logic [31:0] open_time_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]  valve_index;
        logic        status;
        logic        is_open;
        logic [16:0] position_cmd;
        logic [16:0] position_out;
        logic        last;
    } t_out;

    typedef struct packed {
        t_job_kind   kind;
        logic [1:0]  valve;
        logic [31:0] open_time_ms;
    } t_job;

    typedef struct packed {
        logic [16:0] limit0;
        logic [16:0] limit1;
        logic        flip0;
        logic        flip1;
        logic [15:0] hold_time_ms;
        logic [16:0] backoff_fraction;
    } t_cfg;

endpackage

>>> rtl/tvsc_regs.sv
module tvsc_regs
    import tvsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit0           <= ONE_Q16;
            r_cfg.limit1           <= ONE_Q16;
            r_cfg.flip0            <= 1'b0;
            r_cfg.flip1            <= 1'b0;
            r_cfg.hold_time_ms     <= 16'd1000;
            r_cfg.backoff_fraction <= 17'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_LIMIT0:  r_cfg.limit0           <= pwdata[16:0];
                REG_LIMIT1:  r_cfg.limit1           <= pwdata[16:0];
                REG_FLIP0:   r_cfg.flip0            <= pwdata[0];
                REG_FLIP1:   r_cfg.flip1            <= pwdata[0];
                REG_HOLD:    r_cfg.hold_time_ms     <= pwdata[15:0];
                REG_BACKOFF: r_cfg.backoff_fraction <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LIMIT0:  prdata = {15'd0, r_cfg.limit0};
            REG_LIMIT1:  prdata = {15'd0, r_cfg.limit1};
            REG_FLIP0:   prdata = {31'd0, r_cfg.flip0};
            REG_FLIP1:   prdata = {31'd0, r_cfg.flip1};
            REG_HOLD:    prdata = {16'd0, r_cfg.hold_time_ms};
            REG_BACKOFF: prdata = {15'd0, r_cfg.backoff_fraction};
            default:     prdata = '0;
        endcase
    end

endmodule

>>> rtl/tvsc_front.sv
module tvsc_front
    import tvsc_pkg::*;
#(
    parameter int VALVE_COUNT = 2
) (
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_ready,
    output logic o_push,
    output t_job o_job,
    input  logic i_q_ready
);

    logic valve_ok;

    assign valve_ok   = {30'd0, i_in_data.valve} < VALVE_COUNT;
    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid & i_q_ready;

    always_comb begin
        o_job.valve        = i_in_data.valve;
        o_job.open_time_ms = i_in_data.open_time_ms;
        unique case (t_cmd'(i_in_data.command))
            CMD_TICK:  o_job.kind = JOB_TICK;
            CMD_OPEN:  o_job.kind = valve_ok ? JOB_OPEN : JOB_BAD;
            CMD_CLOSE: o_job.kind = valve_ok ? JOB_CLOSE : JOB_BAD;
            CMD_QUERY: o_job.kind = valve_ok ? JOB_QUERY : JOB_BAD;
            default:   o_job.kind = JOB_BAD;
        endcase
    end

endmodule

>>> rtl/tvsc_queue.sv
module tvsc_queue
    import tvsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_ready = r_count != QUEUE_DEPTH[QPTR_W:0];
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tvsc_back.sv
module tvsc_back
    import tvsc_pkg::*;
#(
    parameter int VALVE_COUNT = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_ready
);

    localparam int VIDX_W = (VALVE_COUNT > 1) ? $clog2(VALVE_COUNT) : 1;

    typedef struct packed {
        logic [1:0]  valve_index;
        logic        bad;
        logic        is_open;
        logic [16:0] pos;
        logic [16:0] lim;
        logic        flip;
        logic        last;
    } t_stage_a;

    typedef struct packed {
        logic [1:0]  valve_index;
        logic        bad;
        logic        is_open;
        logic [16:0] pos;
        logic [33:0] prod;
        logic        flip;
        logic        last;
    } t_stage_b;

    // valve state
    logic [31:0] r_now;
    logic [32:0] r_deadline  [VALVE_COUNT];
    logic        r_open      [VALVE_COUNT];
    logic [31:0] r_last_act  [VALVE_COUNT];
    logic [16:0] r_last_pos  [VALVE_COUNT];
    logic        r_sub;

    logic     r_a_vld, r_b_vld, r_c_vld;
    t_stage_a r_a, n_a;
    t_stage_b r_b;
    t_out     r_c, n_c;

    logic a_ready, b_ready, c_ready, issue;
    logic is_tick, tick_first, tick_final;
    logic [VIDX_W-1:0] vsel;
    logic [31:0] now_use;
    logic        expired, hold, open_after;
    logic [31:0] act_use;
    logic [16:0] back, pos_tick, lim_raw;
    logic [32:0] hold_end;
    logic [33:0] rnd;
    logic [17:0] scaled;
    logic [16:0] sc;

    assign c_ready = !r_c_vld || i_out_ready;
    assign b_ready = !r_b_vld || c_ready;
    assign a_ready = !r_a_vld || b_ready;
    assign issue   = i_q_valid && a_ready;

    assign is_tick    = i_job.kind == JOB_TICK;
    assign tick_first = is_tick && !r_sub;
    assign tick_final = is_tick && ({31'd0, r_sub} == VALVE_COUNT - 1);
    assign o_pop      = issue && (!is_tick || tick_final);

    assign vsel    = is_tick ? VIDX_W'(r_sub) : i_job.valve[VIDX_W-1:0];
    assign now_use = (tick_first && r_now != '1) ? r_now + 32'd1 : r_now;

    // deadline and hold checks for the valve a tick is working on
    assign back       = (i_cfg.backoff_fraction > ONE_Q16) ? ONE_Q16 : i_cfg.backoff_fraction;
    assign expired    = r_open[vsel] && ({1'b0, now_use} >= r_deadline[vsel]);
    assign act_use    = expired ? now_use : r_last_act[vsel];
    assign hold_end   = {1'b0, act_use} + {17'd0, i_cfg.hold_time_ms};
    assign hold       = {1'b0, now_use} < hold_end;
    assign open_after = r_open[vsel] && !expired;

    always_comb begin
        if (open_after) begin
            pos_tick = hold ? ONE_Q16 : ONE_Q16 - back;
        end else begin
            pos_tick = hold ? 17'd0 : back;
        end
    end

    assign lim_raw = (vsel == '0) ? i_cfg.limit0 : i_cfg.limit1;

    always_comb begin
        n_a.valve_index = is_tick ? {1'b0, r_sub} : i_job.valve;
        n_a.bad         = 1'b0;
        n_a.lim         = (lim_raw > ONE_Q16) ? ONE_Q16 : lim_raw;
        n_a.flip        = (vsel == '0) ? i_cfg.flip0 : i_cfg.flip1;
        n_a.last        = !is_tick || tick_final;
        n_a.pos         = r_last_pos[vsel];
        n_a.is_open     = r_open[vsel];
        unique case (i_job.kind)
            JOB_TICK: begin
                n_a.pos     = pos_tick;
                n_a.is_open = open_after;
            end
            JOB_OPEN:  n_a.is_open = 1'b1;
            JOB_CLOSE: n_a.is_open = 1'b0;
            JOB_QUERY: ;
            JOB_BAD: begin
                n_a.bad     = 1'b1;
                n_a.is_open = 1'b0;
                n_a.pos     = 17'd0;
            end
            default: n_a.bad = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
            r_sub <= 1'b0;
            for (int i = 0; i < VALVE_COUNT; i++) begin
                r_deadline[i] <= '0;
                r_open[i]     <= 1'b0;
                r_last_act[i] <= '0;
                r_last_pos[i] <= '0;
            end
        end else if (issue) begin
            unique case (i_job.kind)
                JOB_TICK: begin
                    r_now            <= now_use;
                    r_sub            <= tick_final ? 1'b0 : 1'b1;
                    r_open[vsel]     <= open_after;
                    r_last_act[vsel] <= act_use;
                    r_last_pos[vsel] <= pos_tick;
                end
                JOB_OPEN: begin
                    r_deadline[vsel] <= {1'b0, r_now} + {1'b0, i_job.open_time_ms};
                    r_open[vsel]     <= 1'b1;
                    r_last_act[vsel] <= r_now;
                end
                JOB_CLOSE: begin
                    r_open[vsel]     <= 1'b0;
                    r_last_act[vsel] <= r_now;
                end
                JOB_QUERY, JOB_BAD: ;
                default: ;
            endcase
        end
    end

    // scaling pipeline: select, multiply, round and flip
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_vld <= issue;
            end
            if (b_ready) begin
                r_b_vld <= r_a_vld;
            end
            if (c_ready) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a <= n_a;
        end
        if (b_ready) begin
            r_b.valve_index <= r_a.valve_index;
            r_b.bad         <= r_a.bad;
            r_b.is_open     <= r_a.is_open;
            r_b.pos         <= r_a.pos;
            r_b.prod        <= r_a.pos * r_a.lim;
            r_b.flip        <= r_a.flip;
            r_b.last        <= r_a.last;
        end
        if (c_ready) begin
            r_c <= n_c;
        end
    end

    assign rnd    = r_b.prod + {17'd0, HALF_LSB};
    assign scaled = rnd[33:16];
    assign sc     = (scaled > {1'b0, ONE_Q16}) ? ONE_Q16 : scaled[16:0];

    always_comb begin
        n_c.valve_index  = r_b.valve_index;
        n_c.status       = r_b.bad;
        n_c.is_open      = r_b.is_open;
        n_c.position_cmd = r_b.pos;
        n_c.last         = r_b.last;
        if (r_b.bad) begin
            n_c.position_out = 17'd0;
        end else begin
            n_c.position_out = r_b.flip ? ONE_Q16 - sc : sc;
        end
    end

    assign o_out_valid = r_c_vld;
    assign o_out_data  = r_c;

endmodule

>>> rtl/timed_valve_servo_controller.sv
// Timed valve servo controller for a venting valve (index 0) and a main valve (index 1).
// Items enter a two-entry queue and are executed in order; open, close, status query and
// invalid commands each yield one result, a tick works through the valves one after
// another and yields one result per valve, and items other than ticks issue at one per
// cycle while the output is not stalled. The executor shares one deadline compare and
// one hold-time add per cycle between the valves. Each result then passes a three-stage
// scaling pipeline (limit select, 17x17 multiply, rounding and flip). Configuration is
// written over the APB port at byte address 4 times the register index; the user must
// write it only while no results are outstanding, which the block does not enforce.
module timed_valve_servo_controller
    import tvsc_pkg::*;
#(
    parameter int VALVE_COUNT = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg cfg;
    t_job push_job, head_job;
    logic push, q_ready, q_valid, pop;

    tvsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tvsc_front #(
        .VALVE_COUNT (VALVE_COUNT)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_job      (push_job),
        .i_q_ready  (q_ready)
    );

    tvsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    tvsc_back #(
        .VALVE_COUNT (VALVE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
